[hw/rtl/ckb_pkg.sv]
// Shared types, constants and round functions for the ChaCha20 keystream unit.
`timescale 1ns / 1ps

package ckb_pkg;

    localparam int BLOCKS_PER_REQUEST_DEF = 4;
    localparam int DOUBLE_ROUNDS_DEF      = 10;
    localparam int CMD_DEPTH              = 2;

    localparam int WORD_W      = 32;
    localparam int STATE_WORDS = 16;
    localparam int BLOCK_W     = WORD_W * STATE_WORDS;
    localparam int KEY_W       = 256;
    localparam int NONCE_W     = 96;
    localparam int CTR_W       = 32;
    localparam int KS_W        = 64;
    localparam int BOFF_W      = 2;
    localparam int WOFF_W      = 3;
    localparam int OUT_PAD_W   = 3;
    localparam int OUT_TDATA_W = BOFF_W + WOFF_W + KS_W + OUT_PAD_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NONCE_W-1:0] nonce;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic diag;
    } lane_ctrl_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_DONE
    } eng_state_t;

    localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // Four independent quarter rounds; diag selects the diagonal pattern.
    function automatic state_t chacha_round(state_t s, logic diag);
        state_t     r;
        logic [1:0] col;
        logic [1:0] sh;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        word_t      a;
        word_t      b;
        word_t      c;
        word_t      d;
        r  = s;
        sh = {1'b0, diag};
        for (int i = 0; i < 4; i++)
        begin
            col = 2'(i);
            ia  = {2'd0, col};
            ib  = {2'd1, 2'(col + sh)};
            ic  = {2'd2, 2'(col + (sh << 1))};
            id  = {2'd3, 2'(col + sh + (sh << 1))};
            a = s[ia];
            b = s[ib];
            c = s[ic];
            d = s[id];
            a = a + b; d = rotl(d ^ a, 16);
            c = c + d; b = rotl(b ^ c, 12);
            a = a + b; d = rotl(d ^ a, 8);
            c = c + d; b = rotl(b ^ c, 7);
            r[ia] = a;
            r[ib] = b;
            r[ic] = c;
            r[id] = d;
        end
        return r;
    endfunction

    function automatic state_t init_state(cfg_t cfg, word_t ctr);
        state_t s;
        for (int i = 0; i < 4; i++)
        begin
            s[4'(i)] = SIGMA[2'(i)];
        end
        for (int i = 0; i < 8; i++)
        begin
            s[4'(4 + i)] = cfg.key[WORD_W*i +: WORD_W];
        end
        s[12] = ctr;
        s[13] = cfg.nonce[31:0];
        s[14] = cfg.nonce[63:32];
        s[15] = cfg.nonce[95:64];
        return s;
    endfunction

endpackage

[hw/rtl/ckb_cmd_queue.sv]
// Two-entry queue of block counters between the input side and the round engine.
`timescale 1ns / 1ps

module ckb_cmd_queue
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  logic [ckb_pkg::CTR_W-1:0] push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output logic [ckb_pkg::CTR_W-1:0] pop_data
);

    localparam int PTR_W = $clog2(ckb_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(ckb_pkg::CMD_DEPTH + 1);

    logic [ckb_pkg::CTR_W-1:0] entry_reg [ckb_pkg::CMD_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg;
    logic [PTR_W-1:0]          rd_ptr_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      do_push;
    logic                      do_pop;

    assign push_ready = (cnt_reg != CNT_W'(ckb_pkg::CMD_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/ckb_block_lane.sv]
// One ChaCha20 block lane: holds the working state and runs one round per step.
`timescale 1ns / 1ps

module ckb_block_lane
(
    input  logic                        clk,
    input  ckb_pkg::lane_ctrl_t         ctrl,
    input  ckb_pkg::cfg_t               cfg,
    input  logic [ckb_pkg::CTR_W-1:0]   counter,
    output logic [ckb_pkg::BLOCK_W-1:0] block
);

    ckb_pkg::state_t           work_reg;
    logic [ckb_pkg::CTR_W-1:0] ctr_reg;
    ckb_pkg::state_t           init;
    ckb_pkg::state_t           sum;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            work_reg <= ckb_pkg::init_state(cfg, counter);
            ctr_reg  <= counter;
        end
        else if (ctrl.step)
        begin
            work_reg <= ckb_pkg::chacha_round(work_reg, ctrl.diag);
        end
    end

    // Init-state feed-forward; user holds key, nonce while request open; unchecked.
    always_comb
    begin
        init = ckb_pkg::init_state(cfg, ctr_reg);
        for (int i = 0; i < ckb_pkg::STATE_WORDS; i++)
        begin
            sum[4'(i)] = work_reg[4'(i)] + init[4'(i)];
        end
    end

    assign block = sum;

endmodule

[hw/rtl/ckb_engine.sv]
// Round engine: one lane per block, sequenced through all rounds of a request.
`timescale 1ns / 1ps

module ckb_engine
#(
    parameter int BLOCKS_PER_REQUEST = ckb_pkg::BLOCKS_PER_REQUEST_DEF,
    parameter int DOUBLE_ROUNDS      = ckb_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  ckb_pkg::cfg_t                                  cfg,
    input  logic                                           cmd_valid,
    output logic                                           cmd_ready,
    input  logic [ckb_pkg::CTR_W-1:0]                      cmd_counter,
    output logic                                           done,
    input  logic                                           done_ack,
    output logic [BLOCKS_PER_REQUEST*ckb_pkg::BLOCK_W-1:0] blocks
);

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int RND_W  = $clog2(ROUNDS);

    ckb_pkg::eng_state_t state_reg;
    ckb_pkg::eng_state_t state_next;
    logic [RND_W-1:0]    rnd_reg;
    logic [RND_W-1:0]    rnd_next;
    ckb_pkg::lane_ctrl_t ctrl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ckb_pkg::ENG_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        done       = 1'b0;
        unique case (state_reg)
            ckb_pkg::ENG_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    rnd_next   = '0;
                    state_next = ckb_pkg::ENG_RUN;
                end
            end
            ckb_pkg::ENG_RUN:
            begin
                ctrl.step = 1'b1;
                ctrl.diag = rnd_reg[0];
                rnd_next  = rnd_reg + RND_W'(1);
                if (rnd_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ckb_pkg::ENG_DONE;
                end
            end
            ckb_pkg::ENG_DONE:
            begin
                done = 1'b1;
                if (done_ack)
                begin
                    state_next = ckb_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ckb_pkg::ENG_IDLE;
            end
        endcase
    end

    for (genvar b = 0; b < BLOCKS_PER_REQUEST; b++)
    begin : g_lane
        logic [ckb_pkg::CTR_W-1:0] lane_ctr;

        assign lane_ctr = cmd_counter + ckb_pkg::CTR_W'(b);

        ckb_block_lane u_lane
        (
            .clk     (clk),
            .ctrl    (ctrl),
            .cfg     (cfg),
            .counter (lane_ctr),
            .block   (blocks[b*ckb_pkg::BLOCK_W +: ckb_pkg::BLOCK_W])
        );
    end

endmodule

[hw/rtl/ckb_out_shifter.sv]
// Output buffer: takes all finished blocks at once and shifts out one 64-bit word per transfer.
`timescale 1ns / 1ps

module ckb_out_shifter
#(
    parameter int BLOCKS_PER_REQUEST = ckb_pkg::BLOCKS_PER_REQUEST_DEF
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           load,
    input  logic [BLOCKS_PER_REQUEST*ckb_pkg::BLOCK_W-1:0] blocks,
    output logic                                           space,
    output logic                                           m_valid,
    input  logic                                           m_ready,
    output logic [ckb_pkg::OUT_TDATA_W-1:0]                m_data,
    output logic                                           m_last
);

    localparam int BUF_W = BLOCKS_PER_REQUEST * ckb_pkg::BLOCK_W;
    localparam int BL_W  = $clog2(BLOCKS_PER_REQUEST + 1);

    logic [BUF_W-1:0]              buf_reg;
    logic [BL_W-1:0]               blk_left_reg;
    logic [ckb_pkg::WOFF_W-1:0]    word_cnt_reg;
    logic [ckb_pkg::BOFF_W-1:0]    blk_cnt_reg;
    logic                          take;
    logic                          word_end;

    assign m_valid  = (blk_left_reg != '0);
    assign take     = m_valid && m_ready;
    assign word_end = (word_cnt_reg == '1);
    assign m_last   = (blk_left_reg == BL_W'(1)) && word_end;
    assign space    = !m_valid || (m_ready && m_last);
    assign m_data   = {ckb_pkg::OUT_PAD_W'(0), buf_reg[ckb_pkg::KS_W-1:0],
                       word_cnt_reg, blk_cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_left_reg <= '0;
            word_cnt_reg <= '0;
            blk_cnt_reg  <= '0;
        end
        else if (load)
        begin
            blk_left_reg <= BL_W'(BLOCKS_PER_REQUEST);
            word_cnt_reg <= '0;
            blk_cnt_reg  <= '0;
        end
        else if (take)
        begin
            word_cnt_reg <= word_cnt_reg + ckb_pkg::WOFF_W'(1);
            if (word_end)
            begin
                blk_left_reg <= blk_left_reg - BL_W'(1);
                blk_cnt_reg  <= blk_cnt_reg + ckb_pkg::BOFF_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= blocks;
        end
        else if (take)
        begin
            buf_reg <= {ckb_pkg::KS_W'(0), buf_reg[BUF_W-1:ckb_pkg::KS_W]};
        end
    end

endmodule

[hw/rtl/chacha20_keystream_blocks_unit.sv]
// Top level of the ChaCha20 keystream unit: configuration registers and block wiring.
//
//   channel   direction  payload (low bit first)                                 end marker
//   s_axis    in         first_counter[31:0]                                     -
//   m_axis    out        block_offset[1:0] word_offset[4:2] keystream[68:5] pad  tlast=last_word
//   cfg       in         cfg_index selects key_part_0..3, nonce_low, nonce_high  -
//
// A request yields BLOCKS_PER_REQUEST*8 output words, one per cycle while m_axis_tready is high, so
// with the defaults the output port, not the engine, sets the sustained request rate.
// Each lane runs one round per cycle; loading a counter, running all rounds and handing over the
// blocks are hidden behind the previous request's output words with the defaults.
// Reset clears the control state and all configuration registers to zero.
// A stalled output keeps the engine holding finished blocks; the queue takes counters until full.
`timescale 1ns / 1ps

module chacha20_keystream_blocks_unit
#(
    parameter int BLOCKS_PER_REQUEST = ckb_pkg::BLOCKS_PER_REQUEST_DEF,
    parameter int DOUBLE_ROUNDS      = ckb_pkg::DOUBLE_ROUNDS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ckb_pkg::CTR_W-1:0]          s_axis_tdata,  // first_counter
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ckb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // block_offset, word_offset, keystream
    output logic                               m_axis_tlast,
    input  logic                               cfg_we,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BLOCKS_W = BLOCKS_PER_REQUEST * ckb_pkg::BLOCK_W;

    logic [63:0]               key0_reg;
    logic [63:0]               key1_reg;
    logic [63:0]               key2_reg;
    logic [63:0]               key3_reg;
    logic [63:0]               nonce_low_reg;
    logic [31:0]               nonce_high_reg;
    ckb_pkg::cfg_t             cfg;
    logic                      cmd_valid;
    logic                      cmd_ready;
    logic [ckb_pkg::CTR_W-1:0] cmd_counter;
    logic                      eng_done;
    logic                      out_space;
    logic                      load;
    logic [BLOCKS_W-1:0]       blocks;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg       <= '0;
            key1_reg       <= '0;
            key2_reg       <= '0;
            key3_reg       <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ckb_pkg::REG_KEY_PART_0: key0_reg       <= cfg_data;
                ckb_pkg::REG_KEY_PART_1: key1_reg       <= cfg_data;
                ckb_pkg::REG_KEY_PART_2: key2_reg       <= cfg_data;
                ckb_pkg::REG_KEY_PART_3: key3_reg       <= cfg_data;
                ckb_pkg::REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                ckb_pkg::REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.key   = {key3_reg, key2_reg, key1_reg, key0_reg};
    assign cfg.nonce = {nonce_high_reg, nonce_low_reg};
    assign load      = eng_done && out_space;

    ckb_cmd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_data  (s_axis_tdata),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_data   (cmd_counter)
    );

    ckb_engine
    #(
        .BLOCKS_PER_REQUEST (BLOCKS_PER_REQUEST),
        .DOUBLE_ROUNDS      (DOUBLE_ROUNDS)
    )
    u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_counter (cmd_counter),
        .done        (eng_done),
        .done_ack    (load),
        .blocks      (blocks)
    );

    ckb_out_shifter
    #(
        .BLOCKS_PER_REQUEST (BLOCKS_PER_REQUEST)
    )
    u_out
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .blocks  (blocks),
        .space   (out_space),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule
